// ----- sv/mttsl_pkg.sv -----
// mttsl_pkg: shared types and constants for the time-to-sample lookup block
// no dependencies; used by every module of the block

package mttsl_pkg;

  // action codes of an input item
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES    = 2'd1;

  // register reset values
  localparam logic [31:0] TIME_SCALE_RST = 32'd1000;
  localparam logic [8:0]  ENTRIES_RST    = 9'd0;

  // default table size
  localparam int TABLE_DEPTH_DEF = 256;

  // classified command passed from the front end to the back end
  typedef struct packed {
    logic        is_query;
    logic [7:0]  entry_index;
    logic [31:0] run_count;
    logic [31:0] run_duration;
    logic [31:0] media_time;
  } cmd_t;

endpackage

// ----- sv/mttsl_in_if.sv -----
// mttsl_in_if: input channel carrying write and query items
// depends on nothing beyond standard types

interface mttsl_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  entry_index;
  logic [31:0] run_sample_count;
  logic [31:0] run_sample_duration;
  logic [31:0] time_seconds;

  modport source (
    output valid, action, entry_index, run_sample_count, run_sample_duration, time_seconds,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, run_sample_count, run_sample_duration, time_seconds,
    output ready
  );
endinterface

// ----- sv/mttsl_out_if.sv -----
// mttsl_out_if: result channel carrying sample lookup results
// depends on nothing beyond standard types

interface mttsl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_index;
  logic [31:0] media_time;
  logic        beyond_end;

  modport source (
    output valid, sample_index, media_time, beyond_end,
    input  ready
  );
  modport sink (
    input  valid, sample_index, media_time, beyond_end,
    output ready
  );
endinterface

// ----- sv/media_time_to_sample_lookup.sv -----
// media_time_to_sample_lookup: top level of the time-to-sample lookup block
// depends on mttsl_pkg, mttsl_in_if, mttsl_out_if, mttsl_front, mttsl_queue, mttsl_back
//
//   channel   direction  payload
//   in_ch     sink       action, entry_index, run_sample_count,
//                        run_sample_duration, time_seconds
//   out_ch    source     sample_index, media_time, beyond_end
//   cfg       write      cfg_we, cfg_index, cfg_data
//
// a write item passes the front stage register and the queue, is stored when the back
// end is idle and gives no result; a query takes the same path, then starts its walk;
// each run that fits passes read, multiply and compare, then a bit-serial divide and
// result load follow, or the result load alone when the runs in use end first; front
// end and 2-entry queue keep accepting items while a query walks; a result waits in
// the output register while out_ch.ready is low; rst is synchronous, run table not cleared

module media_time_to_sample_lookup #(
  parameter int TABLE_DEPTH = mttsl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mttsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mttsl_pkg::CFG_DATA_W-1:0]     cfg_data,
  mttsl_in_if.sink                             in_ch,
  mttsl_out_if.source                          out_ch
);

  logic [31:0]     time_scale;
  logic [8:0]      entries_in_use;
  logic            f_valid;
  logic            f_ready;
  mttsl_pkg::cmd_t f_cmd;
  logic            q_valid;
  logic            q_ready;
  mttsl_pkg::cmd_t q_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_scale     <= mttsl_pkg::TIME_SCALE_RST;
      entries_in_use <= mttsl_pkg::ENTRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mttsl_pkg::CFG_TIME_SCALE: time_scale     <= cfg_data[31:0];
        mttsl_pkg::CFG_ENTRIES:    entries_in_use <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // accept and classify
  mttsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .time_scale (time_scale),
    .in_ch      (in_ch),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  // command queue
  mttsl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // table store and walk
  mttsl_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .entries_in_use (entries_in_use),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd),
    .out_ch         (out_ch)
  );

endmodule

// ----- sv/mttsl_front.sv -----
// mttsl_front: accepts input items, classifies them and converts query time
// depends on mttsl_pkg and mttsl_in_if

module mttsl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         time_scale,
  mttsl_in_if.sink            in_ch,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output mttsl_pkg::cmd_t     cmd
);

  logic [31:0] media_lo;

  // low 32 bits of seconds times timescale
  assign media_lo = in_ch.time_seconds * time_scale;

  // stage register frees as soon as the queue takes its command
  assign in_ch.ready = !cmd_valid || cmd_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ch.ready) begin
      cmd_valid <= in_ch.valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd.is_query     <= (in_ch.action == mttsl_pkg::ACT_QUERY);
      cmd.entry_index  <= in_ch.entry_index;
      cmd.run_count    <= in_ch.run_sample_count;
      cmd.run_duration <= in_ch.run_sample_duration;
      cmd.media_time   <= media_lo;
    end
  end

endmodule

// ----- sv/mttsl_queue.sv -----
// mttsl_queue: two-entry command queue between front and back end
// depends on mttsl_pkg

module mttsl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  mttsl_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mttsl_pkg::cmd_t pop_cmd
);

  mttsl_pkg::cmd_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- sv/mttsl_back.sv -----
// mttsl_back: run table storage and the query walk with its divider
// depends on mttsl_pkg and mttsl_out_if

module mttsl_back #(
  parameter int TABLE_DEPTH = mttsl_pkg::TABLE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [8:0]      entries_in_use,
  input  logic            q_valid,
  output logic            q_ready,
  input  mttsl_pkg::cmd_t q_cmd,
  mttsl_out_if.source     out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [63:0]   mem [TABLE_DEPTH];
  logic [63:0]   rd_data;
  logic [RW-1:0] run_ctr;
  logic [RW-1:0] run_limit;
  logic [31:0]   rem;
  logic [31:0]   count;
  logic [31:0]   media;
  logic [31:0]   run_n;
  logic [31:0]   run_d;
  logic [63:0]   prod;
  logic [31:0]   div_q;
  logic [31:0]   div_r;
  logic [4:0]    div_cnt;
  logic [31:0]   res_index;
  logic          res_beyond;
  logic          out_valid;
  logic [31:0]   out_index;
  logic [31:0]   out_media;
  logic          out_beyond;

  logic          pop;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   limit32;
  logic          walk_done;
  logic          run_fits;
  logic [32:0]   div_sh;
  logic          div_bit;
  logic [32:0]   div_diff;
  logic [31:0]   quot_next;
  logic          out_load;

  assign q_ready = (state == S_IDLE);
  assign pop     = q_valid && q_ready;
  assign wr_en   = pop && !q_cmd.is_query && (32'(q_cmd.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(q_cmd.entry_index);

  // runs in use, limited to the table size
  assign limit32 = (32'(entries_in_use) > 32'(TABLE_DEPTH)) ?
                   32'(TABLE_DEPTH) : 32'(entries_in_use);

  assign walk_done = (run_ctr == run_limit);
  // whole run ends at or before media time
  assign run_fits  = (prod <= {32'd0, rem});

  // one restoring divide step of rem by the run duration
  assign div_sh    = {div_r, div_q[31]};
  assign div_diff  = div_sh - {1'b0, run_d};
  assign div_bit   = !div_diff[32];
  assign quot_next = {div_q[30:0], div_bit};

  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);

  // walk sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop && q_cmd.is_query) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = walk_done ? S_OUT : S_MUL;
      S_MUL:  state_next = S_CMP;
      S_CMP:  state_next = run_fits ? S_READ : S_DIV;
      S_DIV: begin
        if (div_cnt == 5'd31) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // run table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {q_cmd.run_count, q_cmd.run_duration};
    end
    if (state == S_READ && !walk_done) begin
      rd_data <= mem[run_ctr[AW-1:0]];
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop && q_cmd.is_query) begin
          media     <= q_cmd.media_time;
          rem       <= q_cmd.media_time;
          count     <= 32'd0;
          run_ctr   <= '0;
          run_limit <= RW'(limit32);
        end
      end
      S_READ: begin
        if (walk_done) begin
          res_index  <= 32'd0;
          res_beyond <= 1'b1;
        end
      end
      S_MUL: begin
        run_n <= rd_data[63:32];
        run_d <= rd_data[31:0];
        prod  <= 64'(rd_data[63:32]) * 64'(rd_data[31:0]);
      end
      S_CMP: begin
        if (run_fits) begin
          count   <= count + run_n;
          rem     <= rem - prod[31:0];
          run_ctr <= run_ctr + RW'(1);
        end else begin
          div_q   <= rem;
          div_r   <= 32'd0;
          div_cnt <= 5'd0;
        end
      end
      S_DIV: begin
        div_q   <= quot_next;
        div_r   <= div_bit ? div_diff[31:0] : div_sh[31:0];
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'd31) begin
          res_index  <= count + quot_next;
          res_beyond <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index  <= res_index;
      out_media  <= media;
      out_beyond <= res_beyond;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sample_index = out_index;
  assign out_ch.media_time   = out_media;
  assign out_ch.beyond_end   = out_beyond;

endmodule
